// ----- rtl/pwmcap_pkg.sv -----
// shared types and constants for the pwm input capture meter
`default_nettype none
package pwmcap_pkg;

  localparam int unsigned CLOCK_HZ = 16000000;

  localparam int CAP_W   = 16;
  localparam int CNT8_W  = 8;
  localparam int FREQ_W  = 24;
  localparam int DUTY_W  = 8;
  localparam int SHIFT_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = SHIFT_W;

  localparam int DIV_STEPS = FREQ_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CNT8_W-1:0] CNT_MAX     = 8'hFF;
  localparam logic [CNT8_W-1:0] OVF_LIMIT   = 8'd2;
  localparam logic [CNT8_W-1:0] MIN_CAPS    = 8'd3;
  localparam logic [FREQ_W-1:0] DUTY_CLAMP  = 24'd255;

  typedef enum logic [1:0] {
    OP_RISE  = 2'd0,
    OP_FALL  = 2'd1,
    OP_OVF   = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_STOPPED  = 3'd1,
    STAT_OVERFLOW = 3'd2,
    STAT_NODATA   = 3'd3,
    STAT_ZEROPER  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESCALE = 1'd0,
    REG_RUNNING  = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_DONE = 2'd2
  } fsm_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic query_err;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/pwmcap_ctrl.sv -----
// controller state machine: handshakes, divider step count, result hold
`default_nettype none
module pwmcap_ctrl
  import pwmcap_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic [1:0] in_op,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  fsm_t              state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    in_tready     = 1'b0;
    cmd           = '0;
    acc           = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        acc        = in_tvalid;
        cmd.accept = acc;
        if (acc && (op_t'(in_op) == OP_QUERY)) begin
          step_nxt  = '0;
          state_nxt = stat.query_err ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ----- rtl/pwmcap_dp.sv -----
// datapath: config and capture state, status check, two serial dividers, result register
`default_nettype none
module pwmcap_dp
  import pwmcap_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [1:0]            in_op,
  input  wire logic [CAP_W-1:0]      in_cap,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  output logic [2:0]                 out_status,
  output logic [FREQ_W-1:0]          out_freq,
  output logic [DUTY_W-1:0]          out_duty
);

  logic [SHIFT_W-1:0] prescale_shift_r;
  logic               running_r;
  logic [CAP_W-1:0]   prev_rise_r, last_rise_r, high_ticks_r;
  logic [CNT8_W-1:0]  ovf_cnt_r, cap_cnt_r;

  logic [FREQ_W-1:0]  num_f_r, num_d_r;
  logic [CAP_W-1:0]   rem_f_r, rem_d_r, div_r;
  status_t            qstat_r;

  logic [CAP_W-1:0]   period;
  status_t            qstat;
  logic [FREQ_W-1:0]  ftimer, duty_num;
  logic [CAP_W:0]     trial_f, trial_d;
  logic               ge_f, ge_d;
  logic [CAP_W-1:0]   rem_f_nxt, rem_d_nxt;
  logic [CNT8_W-1:0]  cap_cnt_inc;

  // status of a query against the current state
  always_comb begin
    period = last_rise_r - prev_rise_r;
    if (!running_r) begin
      qstat = STAT_STOPPED;
    end else if (ovf_cnt_r > OVF_LIMIT) begin
      qstat = STAT_OVERFLOW;
    end else if (cap_cnt_r < MIN_CAPS) begin
      qstat = STAT_NODATA;
    end else if (period == '0) begin
      qstat = STAT_ZEROPER;
    end else begin
      qstat = STAT_OK;
    end
    stat.query_err = (qstat != STAT_OK);
  end

  assign ftimer      = FREQ_W'(CLOCK_HZ >> prescale_shift_r);
  assign duty_num    = {high_ticks_r, 8'h00} - {8'h00, high_ticks_r};
  assign cap_cnt_inc = (cap_cnt_r == CNT_MAX) ? cap_cnt_r : cap_cnt_r + 1'b1;

  // one restoring step of each divider
  always_comb begin
    trial_f   = {rem_f_r, num_f_r[FREQ_W-1]};
    trial_d   = {rem_d_r, num_d_r[FREQ_W-1]};
    ge_f      = (trial_f >= {1'b0, div_r});
    ge_d      = (trial_d >= {1'b0, div_r});
    rem_f_nxt = ge_f ? CAP_W'(trial_f - {1'b0, div_r}) : trial_f[CAP_W-1:0];
    rem_d_nxt = ge_d ? CAP_W'(trial_d - {1'b0, div_r}) : trial_d[CAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_shift_r <= '0;
      running_r        <= 1'b0;
      prev_rise_r      <= '0;
      last_rise_r      <= '0;
      high_ticks_r     <= '0;
      ovf_cnt_r        <= '0;
      cap_cnt_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (reg_idx_t'(cfg_index))
          REG_PRESCALE: prescale_shift_r <= cfg_wdata;
          REG_RUNNING:  running_r        <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        case (op_t'(in_op))
          OP_RISE: begin
            prev_rise_r <= last_rise_r;
            last_rise_r <= in_cap;
            cap_cnt_r   <= cap_cnt_inc;
            ovf_cnt_r   <= '0;
          end
          OP_FALL: begin
            high_ticks_r <= in_cap - last_rise_r;
            cap_cnt_r    <= cap_cnt_inc;
            ovf_cnt_r    <= '0;
          end
          OP_OVF: begin
            if (ovf_cnt_r != CNT_MAX) begin
              ovf_cnt_r <= ovf_cnt_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // divider and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept && (op_t'(in_op) == OP_QUERY)) begin
      qstat_r <= qstat;
      num_f_r <= ftimer;
      num_d_r <= duty_num;
      rem_f_r <= '0;
      rem_d_r <= '0;
      div_r   <= period;
    end else if (cmd.step) begin
      num_f_r <= {num_f_r[FREQ_W-2:0], ge_f};
      num_d_r <= {num_d_r[FREQ_W-2:0], ge_d};
      rem_f_r <= rem_f_nxt;
      rem_d_r <= rem_d_nxt;
    end
    if (cmd.load_out) begin
      out_status <= qstat_r;
      if (qstat_r != STAT_OK) begin
        out_freq <= '0;
        out_duty <= '0;
      end else begin
        out_freq <= num_f_r;
        out_duty <= (num_d_r > DUTY_CLAMP) ? DUTY_CLAMP[DUTY_W-1:0] : num_d_r[DUTY_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pwm_input_capture_meter_unit.sv -----
// top level of the pwm input capture meter
//
//  channel | dir | handshake               | payload
//  in_     | in  | in_tvalid / in_tready   | tuser: opcode, tdata: capture_value
//  out_    | out | out_tvalid / out_tready | tuser: status, tdata: frequency, duty
//  cfg_    | in  | cfg_wr_en               | cfg_index, cfg_wdata
//
// capture and overflow items give no result and leave the input ready for the next item
// a query on an error status goes straight to the result, else it first runs the 24 shared
// steps of the two bit-serial dividers (frequency and duty run side by side)
// the result sits in an output register; a new item is taken while it waits,
// but a finished query holds until the result register is free
// rst_n is synchronous and clears config, capture state and counters
`default_nettype none
module pwm_input_capture_meter_unit
  import pwmcap_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [1:0]            in_tuser,   // [1:0] opcode
  input  wire logic [15:0]           in_tdata,   // [15:0] capture_value
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [2:0]                 out_tuser,  // [2:0] status
  output logic [31:0]                out_tdata,  // [23:0] frequency, [31:24] duty
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [FREQ_W-1:0] freq;
  logic [DUTY_W-1:0] duty;

  pwmcap_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  pwmcap_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_cap     (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (out_tuser),
    .out_freq   (freq),
    .out_duty   (duty)
  );

  assign out_tdata = {duty, freq};

  // error results carry no measurement
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != STAT_OK)) |-> (out_tdata == '0))
    else $error("error result with nonzero payload");

  // a query keeps the block busy on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_QUERY)) |=> !in_tready)
    else $error("input taken during a query");

  // other items leave the input ready on the next cycle
  a_event_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != OP_QUERY)) |=> in_tready)
    else $error("event item stalled the input");

endmodule
`default_nettype wire

// ----- test/pwm_input_capture_meter_unit_tb.sv -----
// testbench for the pwm input capture meter: random capture/query streams checked against a predictor
`timescale 1ns / 1ps
module pwm_input_capture_meter_unit_tb;
  import pwmcap_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [15:0] val;
  } capture_item_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] freq;
    logic [7:0]  duty;
  } meter_result_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 500;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [1:0]            in_tuser = '0;   // [1:0] opcode
  logic [15:0]           in_tdata = '0;   // [15:0] capture_value
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2:0]            out_tuser;       // [2:0] status
  logic [31:0]           out_tdata;       // [23:0] frequency, [31:24] duty
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  capture_item_t stim_q[$];
  meter_result_t meter_q[$];

  // predictor state
  logic [3:0]  prescale_sh = '0;
  logic        timer_on = 1'b0;
  logic [15:0] prev_rise = '0;
  logic [15:0] last_rise = '0;
  logic [15:0] high_ticks = '0;
  logic [7:0]  ovf_cnt = '0;
  logic [7:0]  cap_cnt = '0;

  int  items_queued = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  err_cnt = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1'b1;

  int unsigned shift_list[6] = '{0, 3, 6, 8, 10, 15};

  pwm_input_capture_meter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void count_capture();
    if (cap_cnt != 8'hFF) cap_cnt = cap_cnt + 8'd1;
    ovf_cnt = '0;
  endfunction

  function automatic void meter_apply(op_t op, logic [15:0] val);
    meter_result_t r;
    logic [15:0]   period;
    int unsigned   ftimer;
    int unsigned   duty_raw;
    case (op)
      OP_RISE: begin
        prev_rise = last_rise;
        last_rise = val;
        count_capture();
      end
      OP_FALL: begin
        high_ticks = val - last_rise;
        count_capture();
      end
      OP_OVF: begin
        if (ovf_cnt != 8'hFF) ovf_cnt = ovf_cnt + 8'd1;
      end
      default: begin
        period = last_rise - prev_rise;
        r = '{status: STAT_OK, freq: '0, duty: '0};
        if (!timer_on) begin
          r.status = STAT_STOPPED;
        end else if (ovf_cnt > 8'd2) begin
          r.status = STAT_OVERFLOW;
        end else if (cap_cnt < 8'd3) begin
          r.status = STAT_NODATA;
        end else if (period == 16'd0) begin
          r.status = STAT_ZEROPER;
        end else begin
          ftimer = CLOCK_HZ >> prescale_sh;
          r.freq = 24'(ftimer / period);
          duty_raw = (255 * int'(high_ticks)) / period;
          if (duty_raw > 255) duty_raw = 255;
          r.duty = 8'(duty_raw);
        end
        meter_q.push_back(r);
      end
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    capture_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        meter_apply(op_t'(in_tuser), in_tdata);
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (stim_q.size() != 0 && (!gaps_on || $urandom_range(0, 99) >= 28)) begin
          nxt = stim_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.op;
          in_tdata <= nxt.val;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver with two long hold-offs
  always @(posedge clk) begin
    meter_result_t want;
    logic          rdy;
    int            hold_left;
    if (rst_n) begin
      rdy = !gaps_on || $urandom_range(0, 99) >= 28;
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (results_seen == 40 || results_seen == 200) hold_left = HOLD_OFF_CYCLES;
        if (meter_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result status=%0d freq=%0d duty=%0d", $time,
                   out_tuser, out_tdata[23:0], out_tdata[31:24]);
        end else begin
          want = meter_q.pop_front();
          if (out_tuser != want.status) begin
            err_cnt++;
            $display("%0t: status expected %0d got %0d", $time, want.status, out_tuser);
          end
          if (out_tdata[23:0] != want.freq) begin
            err_cnt++;
            $display("%0t: frequency expected %0d got %0d", $time, want.freq,
                     out_tdata[23:0]);
          end
          if (out_tdata[31:24] != want.duty) begin
            err_cnt++;
            $display("%0t: duty expected %0d got %0d", $time, want.duty, out_tdata[31:24]);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_item(op_t op, logic [15:0] val);
    stim_q.push_back('{op: op, val: val});
    items_queued++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [3:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_PRESCALE) prescale_sh = val;
    else timer_on = val[0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait until every item is in and every result out, then let the block settle
  task automatic drain();
    do @(posedge clk);
    while (items_sent != items_queued || meter_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic gen_frame();
    logic [15:0] base;
    logic [15:0] period;
    logic [15:0] high;
    int          kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      base = 16'($urandom);
      case ($urandom_range(0, 4))
        0: period = 16'($urandom_range(1, 64));
        1: period = 16'($urandom_range(1, 4000));
        2: period = 16'($urandom_range(1, 65535));
        3: period = 16'($urandom_range(60000, 65535));
        default: period = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 500));
      endcase
      high = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, period));
      push_item(OP_RISE, base);
      push_item(OP_RISE, base + period);
      push_item(OP_FALL, base + period + high);
      repeat ($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)) push_item(OP_OVF, 16'($urandom));
      push_item(OP_QUERY, 16'($urandom));
      if ($urandom_range(0, 3) == 0) push_item(OP_QUERY, 16'($urandom));
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 6)) push_item(op_t'($urandom_range(0, 3)), 16'($urandom));
    end else begin
      repeat ($urandom_range(3, 8)) push_item(OP_OVF, 16'($urandom));
      push_item(OP_QUERY, 16'($urandom));
      if ($urandom_range(0, 1) == 0) begin
        push_item(OP_FALL, 16'($urandom));
        push_item(OP_QUERY, 16'($urandom));
      end
    end
  endtask

  initial begin
    int start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // stopped timer, captures still recorded
    push_item(OP_QUERY, 16'h0000);
    push_item(OP_RISE, 16'h1234);
    drain();
    write_reg(REG_RUNNING, 1'b1);
    write_reg(REG_PRESCALE, 4'd0);
    push_item(OP_QUERY, 16'hFFFF);
    push_item(OP_FALL, 16'h1300);
    push_item(OP_QUERY, 16'h0000);
    push_item(OP_RISE, 16'h1234);
    push_item(OP_QUERY, 16'h0000);
    // period of one tick, high time beyond the period
    push_item(OP_RISE, 16'h1235);
    push_item(OP_FALL, 16'hFFFF);
    push_item(OP_QUERY, 16'h0000);
    push_item(OP_OVF, 16'h0000);
    push_item(OP_OVF, 16'hFFFF);
    push_item(OP_QUERY, 16'h0000);
    push_item(OP_OVF, 16'h0000);
    push_item(OP_QUERY, 16'h0000);
    // full-range period and wrapped high time
    push_item(OP_RISE, 16'h0000);
    push_item(OP_RISE, 16'hFFFF);
    push_item(OP_FALL, 16'h7FFF);
    push_item(OP_QUERY, 16'h0000);
    push_item(OP_RISE, 16'hFFFF);
    push_item(OP_FALL, 16'h0000);
    push_item(OP_QUERY, 16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(REG_PRESCALE, ph < 6 ? 4'(shift_list[ph]) : 4'($urandom_range(0, 15)));
      write_reg(REG_RUNNING, ph == 3 ? 1'b0 : 1'b1);
      gaps_on = (ph != 1);
      if (ph == 4) begin
        // saturate the overflow counter
        repeat (260) push_item(OP_OVF, 16'($urandom));
        push_item(OP_QUERY, 16'($urandom));
        push_item(OP_RISE, 16'($urandom));
        push_item(OP_QUERY, 16'($urandom));
      end
      start = items_queued;
      while (items_queued - start < 160) gen_frame();
    end
    drain();
    repeat (20) @(posedge clk);

    if (err_cnt == 0 && meter_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pwmcap_pkg.sv
rtl/pwmcap_ctrl.sv
rtl/pwmcap_dp.sv
rtl/pwm_input_capture_meter_unit.sv
test/pwm_input_capture_meter_unit_tb.sv
